>>> sv/vn_pkg.sv
// vn_pkg: shared constants and types of the vector normalizer.
// No dependencies; compiled first.
package vn_pkg;

	// One result bit per recurrence stage, bit 14 down to bit 0.
	localparam int NSTEP      = 15;
	// Output format Q1.14.
	localparam int OUT_BITS   = 16;
	localparam int OUT_ONE    = 16384;
	// Scale of the squared component in the rounding test: mag^2 * 2^30.
	localparam int FRAC_SHIFT = 30;
	// Threshold register.
	localparam int          CFG_BITS  = 32;
	localparam logic [31:0] MIN_RESET = 32'd1;

	typedef logic signed [OUT_BITS-1:0] unit_t;
	typedef logic [CFG_BITS-1:0]        cfg_word_t;

endpackage

>>> sv/vn_if.sv
// vn_if: valid/ready channel interfaces of the vector normalizer.
// Depends on vn_pkg.
interface vn_vec_if #(parameter int COMPONENT_BITS = 16);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] vec_x;
	logic signed [COMPONENT_BITS-1:0] vec_y;
	logic signed [COMPONENT_BITS-1:0] vec_z;

	modport source (output valid, vec_x, vec_y, vec_z, input ready);
	modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface vn_unit_if;
	import vn_pkg::*;
	logic  valid;
	logic  ready;
	unit_t unit_x;
	unit_t unit_y;
	unit_t unit_z;
	logic  was_zeroed;

	modport source (output valid, unit_x, unit_y, unit_z, was_zeroed, input ready);
	modport sink   (input valid, unit_x, unit_y, unit_z, was_zeroed, output ready);
endinterface

>>> sv/vector3_normalize.sv
// vector3_normalize: streaming 3-component vector normalizer, Q3.12 in, Q1.14 out.
// Depends on vn_pkg, vn_if (channel interfaces) and vn_scale_lane.
//
//   channel   | dir | transfer when        | payload
//   ----------+-----+----------------------+----------------------------------------
//   vec_ch    | in  | valid && ready       | vec_x, vec_y, vec_z (signed, 12 frac bits)
//   unit_ch   | out | valid && ready       | unit_x, unit_y, unit_z (Q1.14), was_zeroed
//   cfg       | in  | cfg_wr_en            | cfg_wr_data -> min_length_sq
//
// One vector per cycle sustained while unit_ch accepts results; 19 register stages
// lie between the input transfer and the output transfer:
// 3 front stages (magnitude, square, sum), 15 recurrence stages that each
// settle one bit of the scaled magnitude, and one output register.
// arst_n clears all stage valid bits and sets min_length_sq to 1.
// Each stage holds while its successor is full and stalled; bubbles collapse, so
// input transfers continue while a finished result waits until the pipe is full.
module vector3_normalize #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	vn_vec_if.sink              vec_ch,
	vn_unit_if.source           unit_ch,
	input  logic                cfg_wr_en,
	input  vn_pkg::cfg_word_t   cfg_wr_data
);
	import vn_pkg::*;

	localparam int CB = COMPONENT_BITS;
	localparam int LW = 2 * CB;
	// Compare width for the threshold test.
	localparam int CW = (LW > CFG_BITS) ? LW : CFG_BITS;
	// s1..s3, NSTEP recurrence stages, output stage.
	localparam int NS = NSTEP + 4;
	localparam int LANE0 = 3;

	// ---------------- control ----------------
	logic [NS-1:0] v_q;     // valid bit per stage
	logic [NS:0]   rdy;     // stage may load this cycle
	cfg_word_t     min_q;   // min_length_sq

	always_comb begin
		rdy[NS] = unit_ch.ready;
		for (int i = NS - 1; i >= 0; i--) begin
			rdy[i] = !v_q[i] || rdy[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			for (int i = 0; i < NS; i++) begin
				if (rdy[i]) begin
					v_q[i] <= (i == 0) ? vec_ch.valid : v_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_RESET;
		end else if (cfg_wr_en) begin
			min_q <= cfg_wr_data;
		end
	end

	assign vec_ch.ready  = rdy[0];
	assign unit_ch.valid = v_q[NS-1];

	// ---------------- s1: sign and exact magnitude ----------------
	logic [CB-1:0] comp [3];
	logic [CB-1:0] mag_s1 [3];
	logic          neg_s1 [3];

	always_comb begin
		comp[0] = vec_ch.vec_x;
		comp[1] = vec_ch.vec_y;
		comp[2] = vec_ch.vec_z;
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			for (int c = 0; c < 3; c++) begin
				// most negative value maps to 2^(CB-1), no wrap in CB unsigned bits
				mag_s1[c] <= comp[c][CB-1] ? (~comp[c] + 1'b1) : comp[c];
				neg_s1[c] <= comp[c][CB-1];
			end
		end
	end

	// ---------------- s2: squares ----------------
	logic [LW-1:0] sq_s2 [3];
	logic          neg_s2 [3];

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			for (int c = 0; c < 3; c++) begin
				sq_s2[c]  <= LW'(mag_s1[c]) * LW'(mag_s1[c]);
				neg_s2[c] <= neg_s1[c];
			end
		end
	end

	// ---------------- s3: squared length ----------------
	// 3 * 2^(2CB-2) < 2^(2CB), so the sum fits LW bits.
	logic [LW-1:0] len_s3;
	logic [LW-1:0] sq_s3 [3];
	logic          neg_s3 [3];

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			len_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			for (int c = 0; c < 3; c++) begin
				sq_s3[c]  <= sq_s2[c];
				neg_s3[c] <= neg_s2[c];
			end
		end
	end

	// Zero length always zeroes, even with a zero threshold.
	logic zero_now;
	assign zero_now = (len_s3 == '0) || (CW'(len_s3) < CW'(min_q));

	// ---------------- s4..s18: recurrence lanes ----------------
	logic [NSTEP-1:0] q_l [3];
	logic             neg_l [3];
	logic             zero_st [NSTEP];

	for (genvar c = 0; c < 3; c++) begin : g_lane
		vn_scale_lane #(
			.COMPONENT_BITS (COMPONENT_BITS)
		) u_lane (
			.clk     (clk),
			.en      (rdy[LANE0 + NSTEP - 1 : LANE0]),
			.len     (len_s3),
			.sq      (sq_s3[c]),
			.neg     (neg_s3[c]),
			.q_out   (q_l[c]),
			.neg_out (neg_l[c])
		);
	end

	// zero flag rides alongside the lanes
	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTEP; k++) begin
			if (rdy[LANE0 + k]) begin
				zero_st[k] <= (k == 0) ? zero_now : zero_st[k-1];
			end
		end
	end

	// ---------------- s19: saturate, sign, zero override ----------------
	unit_t            unit_s19 [3];
	logic             zero_s19;
	logic [NSTEP-1:0] q_sat [3];
	unit_t            q_ext [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			q_sat[c] = (q_l[c] > NSTEP'(OUT_ONE)) ? NSTEP'(OUT_ONE) : q_l[c];
			q_ext[c] = unit_t'(q_sat[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			zero_s19 <= zero_st[NSTEP-1];
			for (int c = 0; c < 3; c++) begin
				if (zero_st[NSTEP-1]) begin
					unit_s19[c] <= '0;
				end else begin
					unit_s19[c] <= neg_l[c] ? -q_ext[c] : q_ext[c];
				end
			end
		end
	end

	assign unit_ch.unit_x     = unit_s19[0];
	assign unit_ch.unit_y     = unit_s19[1];
	assign unit_ch.unit_z     = unit_s19[2];
	assign unit_ch.was_zeroed = zero_s19;

	// ---------------- checks ----------------
`ifndef SYNTHESIS
	// a zeroed result carries the zero vector
	a_zeroed_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_ch.valid && unit_ch.was_zeroed) |->
			(unit_ch.unit_x == '0 && unit_ch.unit_y == '0 && unit_ch.unit_z == '0))
		else $error("zeroed result with nonzero component");

	// normalized components stay within +-1.0
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(unit_ch.valid && !unit_ch.was_zeroed) |->
			(unit_ch.unit_x <= unit_t'(OUT_ONE) && unit_ch.unit_x >= -unit_t'(OUT_ONE)
			&& unit_ch.unit_y <= unit_t'(OUT_ONE) && unit_ch.unit_y >= -unit_t'(OUT_ONE)
			&& unit_ch.unit_z <= unit_t'(OUT_ONE) && unit_ch.unit_z >= -unit_t'(OUT_ONE)))
		else $error("normalized component out of range");

	// a full, stalled pipe must refuse input
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(&v_q && !unit_ch.ready) |-> !vec_ch.ready)
		else $error("input taken while pipeline full and stalled");
`endif

endmodule

>>> sv/vn_scale_lane.sv
// vn_scale_lane: NSTEP-stage bit-per-stage search for round(mag * 2^14 / sqrt(len)).
// Depends on vn_pkg; stage enables come from the top level.
module vn_scale_lane #(
	parameter int COMPONENT_BITS = 16
) (
	input  logic                          clk,
	input  logic [vn_pkg::NSTEP-1:0]      en,
	input  logic [2*COMPONENT_BITS-1:0]   len,
	input  logic [2*COMPONENT_BITS-1:0]   sq,
	input  logic                          neg,
	output logic [vn_pkg::NSTEP-1:0]      q_out,
	output logic                          neg_out
);
	import vn_pkg::*;

	localparam int LW = 2 * COMPONENT_BITS;
	// t^2 * len with t < 2^16 and len < 2^LW, plus sign and margin.
	localparam int W  = LW + 34;

	typedef logic signed [W-1:0] acc_t;
	typedef logic [NSTEP-1:0]    qv_t;

	// Invariant per stage: q is the result so far, t = 2q - 1,
	// p = t^2 * len, r = t * len, m = mag^2 * 2^30.
	acc_t          p_st [NSTEP];
	acc_t          r_st [NSTEP];
	acc_t          m_st [NSTEP];
	logic [LW-1:0] l_st [NSTEP];
	qv_t           q_st [NSTEP];
	logic          n_st [NSTEP];

	acc_t          p_in [NSTEP];
	acc_t          r_in [NSTEP];
	acc_t          m_in [NSTEP];
	logic [LW-1:0] l_in [NSTEP];
	qv_t           q_in [NSTEP];
	logic          n_in [NSTEP];
	acc_t          p_cand [NSTEP];
	acc_t          r_cand [NSTEP];
	logic          take [NSTEP];

	always_comb begin
		for (int k = 0; k < NSTEP; k++) begin
			if (k == 0) begin
				// q = 0, t = -1
				p_in[k] = acc_t'(len);
				r_in[k] = -acc_t'(len);
				m_in[k] = acc_t'(sq) << FRAC_SHIFT;
				l_in[k] = len;
				q_in[k] = '0;
				n_in[k] = neg;
			end else begin
				p_in[k] = p_st[k-1];
				r_in[k] = r_st[k-1];
				m_in[k] = m_st[k-1];
				l_in[k] = l_st[k-1];
				q_in[k] = q_st[k-1];
				n_in[k] = n_st[k-1];
			end
			// Setting bit b: t grows by 2^(b+1),
			// t'^2 len = p + r*2^(b+2) + len*2^(2b+2).
			p_cand[k] = p_in[k] + (r_in[k] <<< (NSTEP + 1 - k))
				+ (acc_t'(l_in[k]) << (2 * (NSTEP - 1 - k) + 2));
			r_cand[k] = r_in[k] + (acc_t'(l_in[k]) << (NSTEP - k));
			take[k]   = (p_cand[k] <= m_in[k]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NSTEP; k++) begin
			if (en[k]) begin
				p_st[k] <= take[k] ? p_cand[k] : p_in[k];
				r_st[k] <= take[k] ? r_cand[k] : r_in[k];
				m_st[k] <= m_in[k];
				l_st[k] <= l_in[k];
				q_st[k] <= q_in[k] | ({{(NSTEP-1){1'b0}}, take[k]} << (NSTEP - 1 - k));
				n_st[k] <= n_in[k];
			end
		end
	end

	assign q_out   = q_st[NSTEP-1];
	assign neg_out = n_st[NSTEP-1];

endmodule
